FILE: hw/rtl/tsup_pkg.sv
// Shared types and constants of the transport-stream UDP packetizer.
package tsup_pkg;

    // UDP payload: seven 188-byte transport packets
    localparam logic [10:0] PAYLOAD_BYTES   = 11'd1316;
    localparam logic [15:0] MAX_PART_LEN    = 16'd42112;
    localparam logic [15:0] PACKET_ID_RESET = 16'd15796;
    localparam logic [7:0]  TTL_RESET       = 8'd64;

    // Fixed IPv4 header words
    localparam logic [7:0]  IP_VER_IHL      = 8'h45;
    localparam logic [7:0]  IP_PROTO_UDP    = 8'h11;
    localparam logic [15:0] IP_TOTAL_LEN    = 16'h0540;

    localparam logic [1:0]  SEG_COUNT_DIRECT = 2'd2;
    localparam logic [1:0]  SEG_COUNT_SPLIT  = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TTL       = 2'd0,
        CFG_SOURCE_IP = 2'd1,
        CFG_DEST_IP   = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [31:0] part_a_addr;
        logic [15:0] part_a_len;
        logic [31:0] part_b_addr;
        logic [15:0] part_b_len;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  segment_count;
        logic [4:0]  header_slot;
        logic [15:0] packet_id;
        logic [15:0] header_checksum;
        logic [31:0] seg1_addr;
        logic [10:0] seg1_len;
        logic [31:0] seg2_addr;
        logic [10:0] seg2_len;
        logic [16:0] bytes_sent;
        logic        last;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_BASE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic sum;
        logic base;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic short_input;
        logic final_word;
        logic out_free;
    } t_status;

endpackage

FILE: hw/rtl/ts_udp_packetizer.sv
// Top level of the transport-stream UDP packetizer.
// Takes a two-part buffer descriptor and emits one transmit descriptor per
// 1316-byte UDP payload, with header slot, IP identification and IPv4 header
// checksum. An accepted input is loaded, then the address and TTL part of the
// checksum is precomputed; it then emits one descriptor per cycle while the
// output is taken, up to 64 descriptors. An input under one payload gives
// nothing. The output register lets the next input be accepted while the
// last descriptor still waits. Part lengths above 42112 are clamped; bytes
// past the last whole payload are not sent. The user must write
// configuration only while the block is idle; the block does not enforce it.
module ts_udp_packetizer #(
    parameter int HEADER_SLOTS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  tsup_pkg::t_in_word                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output tsup_pkg::t_out_word               o_out_data,
    input  logic                              i_cfg_wr_en,
    input  logic [tsup_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [tsup_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    tsup_pkg::t_cmd    cmd;
    tsup_pkg::t_status status;

    tsup_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tsup_datapath #(
        .HEADER_SLOTS (HEADER_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: hw/rtl/tsup_controller.sv
// Packetizer sequencer: load, checksum setup, then one descriptor per cycle while output is free.
module tsup_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tsup_pkg::t_status i_status,
    output tsup_pkg::t_cmd   o_cmd
);

    tsup_pkg::t_state r_state;
    tsup_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsup_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tsup_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tsup_pkg::ST_SUM;
                end
            end
            tsup_pkg::ST_SUM: begin
                // drop inputs too short for one payload
                if (i_status.short_input) begin
                    n_state = tsup_pkg::ST_IDLE;
                end else begin
                    o_cmd.sum = 1'b1;
                    n_state   = tsup_pkg::ST_BASE;
                end
            end
            tsup_pkg::ST_BASE: begin
                o_cmd.base = 1'b1;
                n_state    = tsup_pkg::ST_EMIT;
            end
            tsup_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.final_word) begin
                        n_state = tsup_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = tsup_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/tsup_datapath.sv
// Datapath of the packetizer: config registers, part cursors, checksum and output word.
module tsup_datapath #(
    parameter int HEADER_SLOTS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tsup_pkg::t_cmd                      i_cmd,
    output tsup_pkg::t_status                   o_status,
    input  tsup_pkg::t_in_word                  i_in_data,
    input  logic                                i_cfg_wr_en,
    input  logic [tsup_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [tsup_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output tsup_pkg::t_out_word                 o_out_data
);

    localparam int SLOT_W = (HEADER_SLOTS > 1) ? $clog2(HEADER_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HEADER_SLOTS - 1);

    localparam logic [15:0] PB16 = {5'd0, tsup_pkg::PAYLOAD_BYTES};
    localparam logic [16:0] PB17 = {6'd0, tsup_pkg::PAYLOAD_BYTES};
    localparam logic [31:0] PB32 = {21'd0, tsup_pkg::PAYLOAD_BYTES};

    // configuration and persistent state
    logic [7:0]        r_ttl;
    logic [31:0]       r_source_ip;
    logic [31:0]       r_dest_ip;
    logic [SLOT_W-1:0] r_slot;
    logic [15:0]       r_pkt_id;
    logic              r_out_valid;

    // per-input working registers
    logic [31:0] r_a_addr;
    logic [15:0] r_a_len;
    logic [31:0] r_b_addr;
    logic [15:0] r_b_len;
    logic [16:0] r_remain;
    logic [16:0] r_sent;
    logic [17:0] r_ip_sum;
    logic [15:0] r_base;
    tsup_pkg::t_out_word r_out;

    logic [15:0] a_len_clamped;
    logic [15:0] b_len_clamped;
    logic [17:0] ip_sum;
    logic [18:0] base_raw;
    logic [16:0] base_fold1;
    logic [15:0] base_fold2;

    logic        a_direct;
    logic [10:0] take;
    logic [1:0]  seg_count;
    logic [10:0] s1_len;
    logic [31:0] s2_addr;
    logic [10:0] s2_len;
    logic [31:0] na_addr;
    logic [15:0] na_len;
    logic [31:0] nb_addr;
    logic [15:0] nb_len;
    logic [16:0] remain_next;
    logic [16:0] sent_next;
    logic [16:0] csum_raw;
    logic [15:0] csum_fold;
    logic [SLOT_W+4:0] slot_ext;
    logic        out_free;

    assign a_len_clamped = (i_in_data.part_a_len > tsup_pkg::MAX_PART_LEN) ?
                           tsup_pkg::MAX_PART_LEN : i_in_data.part_a_len;
    assign b_len_clamped = (i_in_data.part_b_len > tsup_pkg::MAX_PART_LEN) ?
                           tsup_pkg::MAX_PART_LEN : i_in_data.part_b_len;

    // address words of the header, summed once per input
    assign ip_sum = {2'd0, r_source_ip[31:16]} + {2'd0, r_source_ip[15:0]}
                  + {2'd0, r_dest_ip[31:16]} + {2'd0, r_dest_ip[15:0]};

    // fixed header words plus TTL/protocol, folded to 16 bits
    assign base_raw = {1'b0, r_ip_sum}
                    + {3'd0, r_ttl, tsup_pkg::IP_PROTO_UDP}
                    + {3'd0, tsup_pkg::IP_VER_IHL, 8'h00}
                    + {3'd0, tsup_pkg::IP_TOTAL_LEN};
    assign base_fold1 = {1'b0, base_raw[15:0]} + {14'd0, base_raw[18:16]};
    assign base_fold2 = base_fold1[15:0] + {15'd0, base_fold1[16]};

    always_comb begin
        a_direct = (r_a_len >= PB16);
        take     = tsup_pkg::PAYLOAD_BYTES - r_a_len[10:0];
        if (a_direct) begin
            seg_count = tsup_pkg::SEG_COUNT_DIRECT;
            s1_len    = tsup_pkg::PAYLOAD_BYTES;
            s2_addr   = '0;
            s2_len    = '0;
            na_addr   = r_a_addr + PB32;
            na_len    = r_a_len - PB16;
            nb_addr   = r_b_addr;
            nb_len    = r_b_len;
        end else begin
            // payload straddles the wrap: tail of A, head of B
            seg_count = tsup_pkg::SEG_COUNT_SPLIT;
            s1_len    = r_a_len[10:0];
            s2_addr   = r_b_addr;
            s2_len    = take;
            na_addr   = r_a_addr;
            na_len    = '0;
            nb_addr   = r_b_addr + {21'd0, take};
            nb_len    = r_b_len - {5'd0, take};
        end
        // part A used up: B becomes the current part
        if (na_len == 16'd0) begin
            na_addr = nb_addr;
            na_len  = nb_len;
            nb_addr = '0;
            nb_len  = '0;
        end
    end

    assign remain_next = r_remain - PB17;
    assign sent_next   = r_sent + PB17;

    assign csum_raw  = {1'b0, r_base} + {1'b0, r_pkt_id};
    assign csum_fold = csum_raw[15:0] + {15'd0, csum_raw[16]};

    assign slot_ext = (SLOT_W + 5)'(r_slot);

    assign out_free             = !r_out_valid || i_out_ready;
    assign o_status.out_free    = out_free;
    assign o_status.short_input = (r_remain < PB17);
    assign o_status.final_word  = (remain_next < PB17);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl       <= tsup_pkg::TTL_RESET;
            r_source_ip <= '0;
            r_dest_ip   <= '0;
            r_slot      <= '0;
            r_pkt_id    <= tsup_pkg::PACKET_ID_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    tsup_pkg::CFG_TTL:       r_ttl       <= i_cfg_data[7:0];
                    tsup_pkg::CFG_SOURCE_IP: r_source_ip <= i_cfg_data;
                    tsup_pkg::CFG_DEST_IP:   r_dest_ip   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.emit) begin
                r_pkt_id    <= r_pkt_id + 16'd1;
                r_slot      <= (r_slot == SLOT_LAST) ? '0 : r_slot + SLOT_W'(1);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a_addr <= i_in_data.part_a_addr;
            r_a_len  <= a_len_clamped;
            r_b_addr <= i_in_data.part_b_addr;
            r_b_len  <= b_len_clamped;
            r_remain <= {1'b0, a_len_clamped} + {1'b0, b_len_clamped};
            r_sent   <= '0;
        end
        if (i_cmd.sum) begin
            r_ip_sum <= ip_sum;
        end
        if (i_cmd.base) begin
            r_base <= base_fold2;
        end
        if (i_cmd.emit) begin
            r_a_addr <= na_addr;
            r_a_len  <= na_len;
            r_b_addr <= nb_addr;
            r_b_len  <= nb_len;
            r_remain <= remain_next;
            r_sent   <= sent_next;

            r_out.segment_count   <= seg_count;
            r_out.header_slot     <= slot_ext[4:0];
            r_out.packet_id       <= r_pkt_id;
            r_out.header_checksum <= ~csum_fold;
            r_out.seg1_addr       <= r_a_addr;
            r_out.seg1_len        <= s1_len;
            r_out.seg2_addr       <= s2_addr;
            r_out.seg2_len        <= s2_len;
            r_out.bytes_sent      <= sent_next;
            r_out.last            <= (remain_next < PB17);
        end
    end

endmodule
